FILE: hw/rtl/pfsp_pkg.sv
// ----------------------------------------------------------------------------
// pfsp_pkg
// Shared types, constants and helpers of the format specifier parser.
// ----------------------------------------------------------------------------
`default_nettype none

package pfsp_pkg;

  localparam int NUM_BITS   = 32;
  localparam int FIELD_W    = 32;
  localparam int BASE_W     = 5;
  localparam int FLAG_W     = 6;
  localparam int MOD_W      = 7;
  localparam int LEN_W      = 8;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [NUM_BITS-1:0] NUM_MAX  = {1'b0, {(NUM_BITS-1){1'b1}}};
  localparam logic [BASE_W-1:0]   BASE_DEC = BASE_W'(10);
  localparam logic [BASE_W-1:0]   BASE_OCT = BASE_W'(8);
  localparam logic [BASE_W-1:0]   BASE_HEX = BASE_W'(16);
  localparam logic [BASE_W-1:0]   BASE_KEEP = '0;
  localparam logic [NUM_BITS-1:0] BASE_LIMIT = NUM_BITS'(16);
  localparam logic [LEN_W-1:0]    LEN_MAX  = '1;

  // modifier bit positions
  localparam int MB_Z  = 0;
  localparam int MB_J  = 1;
  localparam int MB_LL = 2;
  localparam int MB_L  = 3;
  localparam int MB_HH = 4;
  localparam int MB_H  = 5;
  localparam int MB_BL = 6;

  localparam logic [7:0] CH_BANG = 8'h21;

  typedef enum logic [3:0] {
    CL_CONV  = 4'd0,
    CL_FLAG  = 4'd1,
    CL_DIGIT = 4'd2,
    CL_STAR  = 4'd3,
    CL_DOT   = 4'd4,
    CL_Z     = 4'd5,
    CL_J     = 4'd6,
    CL_LOW_L = 4'd7,
    CL_LOW_H = 4'd8,
    CL_BIG_L = 4'd9,
    CL_OTHER = 4'd10
  } cls_t;

  typedef struct packed {
    logic [7:0]        ch;
    logic [FIELD_W-1:0] star;
    cls_t              cls;
    logic              is_digit;
    logic [3:0]        digit;
    logic [FLAG_W-1:0] flag_oh;
    logic [BASE_W-1:0] conv_base;
  } word_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_NUM  = 4'b0010,
    PH_DOT  = 4'b0100,
    PH_PREC = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    PM_NONE = 3'b001,
    PM_L    = 3'b010,
    PM_H    = 3'b100
  } pend_t;

  function automatic logic [NUM_BITS-1:0] accum(input logic [NUM_BITS-1:0] acc,
                                                input logic [3:0] d);
    logic [NUM_BITS+3:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {NUM_BITS'(0), d};
    if (v > {4'b0000, NUM_MAX}) begin
      return NUM_MAX;
    end
    return v[NUM_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/printf_format_spec_parser_top.sv
// ----------------------------------------------------------------------------
// printf_format_spec_parser_top
// Parses printf conversion specifiers one character per word.
//
//   channel | direction | ports
//   --------+-----------+-------------------------------------------------
//   in      | input     | in_valid, in_stall, in_character, in_star_value
//   out     | output    | out_valid, out_stall, out_* record fields
//
// one character word per cycle sustained while in_stall is low; the word that
// ends the spec yields a record via queue write, then execute into result reg.
// the four-entry queue decouples classification from the parse state update;
// in_stall rises only when the queue is full.
// rst_n is synchronous, active low, and clears parse state and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module printf_format_spec_parser_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [7:0]                        in_character,
  input  wire logic signed [pfsp_pkg::FIELD_W-1:0] in_star_value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [7:0]                             out_conversion_char,
  output logic [pfsp_pkg::FLAG_W-1:0]            out_flag_bits,
  output logic signed [pfsp_pkg::FIELD_W-1:0]    out_field_width,
  output logic signed [pfsp_pkg::FIELD_W-1:0]    out_precision,
  output logic [pfsp_pkg::BASE_W-1:0]            out_number_base,
  output logic [pfsp_pkg::MOD_W-1:0]             out_modifier_bits,
  output logic [7:0]                             out_error_char,
  output logic                                   out_is_error,
  output logic [pfsp_pkg::LEN_W-1:0]             out_spec_length
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_not_empty;
  pfsp_pkg::word_t push_word;
  pfsp_pkg::word_t head_word;

  pfsp_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_character  (in_character),
    .in_star_value (in_star_value),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_word        (push_word)
  );

  pfsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_word (head_word)
  );

  pfsp_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_not_empty         (q_not_empty),
    .q_word              (head_word),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_conversion_char (out_conversion_char),
    .out_flag_bits       (out_flag_bits),
    .out_field_width     (out_field_width),
    .out_precision       (out_precision),
    .out_number_base     (out_number_base),
    .out_modifier_bits   (out_modifier_bits),
    .out_error_char      (out_error_char),
    .out_is_error        (out_is_error),
    .out_spec_length     (out_spec_length)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/pfsp_front.sv
// ----------------------------------------------------------------------------
// pfsp_front
// Input handshake and character classification into a queue word.
// ----------------------------------------------------------------------------
`default_nettype none

module pfsp_front (
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      in_character,
  input  wire logic signed [pfsp_pkg::FIELD_W-1:0] in_star_value,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output pfsp_pkg::word_t                      q_word
);

  pfsp_pkg::cls_t                  cls;
  logic [pfsp_pkg::FLAG_W-1:0]     flag_oh;
  logic [pfsp_pkg::BASE_W-1:0]     conv_base;

  always_comb begin
    cls       = pfsp_pkg::CL_OTHER;
    flag_oh   = '0;
    conv_base = pfsp_pkg::BASE_KEEP;
    unique case (in_character)
      "s", "S", "p", "d", "D", "i", "u", "U", "c", "C", "e", "E", "f", "F",
      "g", "G", "a", "A", "n", "b", "r", "k": cls = pfsp_pkg::CL_CONV;
      "o", "O": begin
        cls       = pfsp_pkg::CL_CONV;
        conv_base = pfsp_pkg::BASE_OCT;
      end
      "x", "X": begin
        cls       = pfsp_pkg::CL_CONV;
        conv_base = pfsp_pkg::BASE_HEX;
      end
      "#": begin cls = pfsp_pkg::CL_FLAG; flag_oh = 6'b000001; end
      "0": begin cls = pfsp_pkg::CL_FLAG; flag_oh = 6'b000010; end
      "-": begin cls = pfsp_pkg::CL_FLAG; flag_oh = 6'b000100; end
      "+": begin cls = pfsp_pkg::CL_FLAG; flag_oh = 6'b001000; end
      " ": begin cls = pfsp_pkg::CL_FLAG; flag_oh = 6'b010000; end
      "'": begin cls = pfsp_pkg::CL_FLAG; flag_oh = 6'b100000; end
      "1", "2", "3", "4", "5", "6", "7", "8", "9": cls = pfsp_pkg::CL_DIGIT;
      "*": cls = pfsp_pkg::CL_STAR;
      ".": cls = pfsp_pkg::CL_DOT;
      "z": cls = pfsp_pkg::CL_Z;
      "j": cls = pfsp_pkg::CL_J;
      "l": cls = pfsp_pkg::CL_LOW_L;
      "h": cls = pfsp_pkg::CL_LOW_H;
      "L": cls = pfsp_pkg::CL_BIG_L;
      default: cls = pfsp_pkg::CL_OTHER;
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_word.ch        = in_character;
    q_word.star      = in_star_value;
    q_word.cls       = cls;
    q_word.is_digit  = (in_character >= "0") && (in_character <= "9");
    q_word.digit     = in_character[3:0];
    q_word.flag_oh   = flag_oh;
    q_word.conv_base = conv_base;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pfsp_queue.sv
// ----------------------------------------------------------------------------
// pfsp_queue
// Short word queue between the classifier and the execution stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pfsp_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire pfsp_pkg::word_t push_word,
  output logic                 full,
  input  wire logic            pop,
  output logic                 not_empty,
  output pfsp_pkg::word_t      head_word
);

  pfsp_pkg::word_t                 mem_r [pfsp_pkg::Q_DEPTH];
  logic [pfsp_pkg::Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [pfsp_pkg::Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [pfsp_pkg::Q_CNT_W-1:0]    cnt_r, cnt_nxt;

  assign full      = (cnt_r == pfsp_pkg::Q_CNT_W'(pfsp_pkg::Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_word = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pfsp_back.sv
// ----------------------------------------------------------------------------
// pfsp_back
// Parse state machine and field registers; loads the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfsp_back (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             q_not_empty,
  input  wire pfsp_pkg::word_t                  q_word,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [7:0]                            out_conversion_char,
  output logic [pfsp_pkg::FLAG_W-1:0]           out_flag_bits,
  output logic signed [pfsp_pkg::FIELD_W-1:0]   out_field_width,
  output logic signed [pfsp_pkg::FIELD_W-1:0]   out_precision,
  output logic [pfsp_pkg::BASE_W-1:0]           out_number_base,
  output logic [pfsp_pkg::MOD_W-1:0]            out_modifier_bits,
  output logic [7:0]                            out_error_char,
  output logic                                  out_is_error,
  output logic [pfsp_pkg::LEN_W-1:0]            out_spec_length
);

  logic [pfsp_pkg::FLAG_W-1:0]   flag_r, flag_nxt;
  logic [pfsp_pkg::FIELD_W-1:0]  width_r, width_nxt;
  logic [pfsp_pkg::FIELD_W-1:0]  prec_r, prec_nxt;
  logic [pfsp_pkg::BASE_W-1:0]   base_r, base_nxt;
  logic [pfsp_pkg::MOD_W-1:0]    mod_r, mod_nxt;
  logic [pfsp_pkg::NUM_BITS-1:0] acc_r, acc_nxt;
  pfsp_pkg::phase_t              phase_r, phase_nxt;
  pfsp_pkg::pend_t               pend_r, pend_nxt;
  logic [pfsp_pkg::LEN_W-1:0]    len_r, len_nxt;

  logic                          valid_r;
  logic [7:0]                    conv_r;
  logic [pfsp_pkg::FLAG_W-1:0]   oflag_r;
  logic [pfsp_pkg::FIELD_W-1:0]  owidth_r;
  logic [pfsp_pkg::FIELD_W-1:0]  oprec_r;
  logic [pfsp_pkg::BASE_W-1:0]   obase_r;
  logic [pfsp_pkg::MOD_W-1:0]    omod_r;
  logic [7:0]                    oerr_r;
  logic                          oiserr_r;
  logic [pfsp_pkg::LEN_W-1:0]    olen_r;

  logic                          adv;
  logic                          fall;
  logic                          stop;
  logic                          emit;
  logic                          is_err;
  logic [pfsp_pkg::FIELD_W-1:0]  acc_ext;
  logic [pfsp_pkg::NUM_BITS-1:0] acc_step;

  assign adv      = q_not_empty && (!valid_r || !out_stall);
  assign q_pop    = adv;
  assign acc_ext  = pfsp_pkg::FIELD_W'(acc_r);
  assign acc_step = pfsp_pkg::accum(acc_r, q_word.digit);

  always_comb begin
    flag_nxt  = flag_r;
    width_nxt = width_r;
    prec_nxt  = prec_r;
    base_nxt  = base_r;
    mod_nxt   = mod_r;
    acc_nxt   = acc_r;
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    len_nxt   = (len_r == pfsp_pkg::LEN_MAX) ? len_r : len_r + 1'b1;
    fall      = 1'b0;
    stop      = 1'b0;
    emit      = 1'b0;
    is_err    = 1'b0;

    unique case (phase_r)
      pfsp_pkg::PH_NUM: begin
        if (q_word.is_digit) begin
          acc_nxt = acc_step;
        end else begin
          phase_nxt = pfsp_pkg::PH_IDLE;
          if (q_word.ch == pfsp_pkg::CH_BANG) begin
            base_nxt = (acc_r > pfsp_pkg::BASE_LIMIT) ? pfsp_pkg::BASE_DEC
                                                      : acc_r[pfsp_pkg::BASE_W-1:0];
          end else begin
            width_nxt = acc_ext;
            fall      = 1'b1;
          end
        end
      end
      pfsp_pkg::PH_DOT: begin
        phase_nxt = pfsp_pkg::PH_IDLE;
        if (q_word.cls == pfsp_pkg::CL_STAR) begin
          prec_nxt = q_word.star;
        end else if (q_word.is_digit) begin
          acc_nxt   = pfsp_pkg::NUM_BITS'(q_word.digit);
          phase_nxt = pfsp_pkg::PH_PREC;
        end else begin
          fall = 1'b1;
        end
      end
      pfsp_pkg::PH_PREC: begin
        if (q_word.is_digit) begin
          acc_nxt = acc_step;
        end else begin
          prec_nxt  = acc_ext;
          phase_nxt = pfsp_pkg::PH_IDLE;
          fall      = 1'b1;
        end
      end
      default: begin
        phase_nxt = pfsp_pkg::PH_IDLE;
        fall      = 1'b1;
      end
    endcase

    if (fall) begin
      pend_nxt = pfsp_pkg::PM_NONE;
      unique case (pend_r)
        pfsp_pkg::PM_L: begin
          if (q_word.cls == pfsp_pkg::CL_LOW_L) begin
            mod_nxt[pfsp_pkg::MB_LL] = 1'b1;
            stop = 1'b1;
          end else begin
            mod_nxt[pfsp_pkg::MB_L] = 1'b1;
          end
        end
        pfsp_pkg::PM_H: begin
          if (q_word.cls == pfsp_pkg::CL_LOW_H) begin
            mod_nxt[pfsp_pkg::MB_HH] = 1'b1;
            stop = 1'b1;
          end else begin
            mod_nxt[pfsp_pkg::MB_H] = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (!stop) begin
        unique case (q_word.cls)
          pfsp_pkg::CL_CONV: begin
            if (q_word.conv_base != pfsp_pkg::BASE_KEEP) begin
              base_nxt = q_word.conv_base;
            end
            emit = 1'b1;
          end
          pfsp_pkg::CL_FLAG:  flag_nxt = flag_nxt | q_word.flag_oh;
          pfsp_pkg::CL_DIGIT: begin
            acc_nxt   = pfsp_pkg::NUM_BITS'(q_word.digit);
            phase_nxt = pfsp_pkg::PH_NUM;
          end
          pfsp_pkg::CL_STAR:  width_nxt = q_word.star;
          pfsp_pkg::CL_DOT:   phase_nxt = pfsp_pkg::PH_DOT;
          pfsp_pkg::CL_Z:     mod_nxt[pfsp_pkg::MB_Z] = 1'b1;
          pfsp_pkg::CL_J:     mod_nxt[pfsp_pkg::MB_J] = 1'b1;
          pfsp_pkg::CL_LOW_L: pend_nxt = pfsp_pkg::PM_L;
          pfsp_pkg::CL_LOW_H: pend_nxt = pfsp_pkg::PM_H;
          pfsp_pkg::CL_BIG_L: mod_nxt[pfsp_pkg::MB_BL] = 1'b1;
          default: begin
            emit   = 1'b1;
            is_err = 1'b1;
          end
        endcase
      end
    end
  end

  // control and parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r  <= '0;
      width_r <= '0;
      prec_r  <= '0;
      base_r  <= pfsp_pkg::BASE_DEC;
      mod_r   <= '0;
      acc_r   <= '0;
      phase_r <= pfsp_pkg::PH_IDLE;
      pend_r  <= pfsp_pkg::PM_NONE;
      len_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (adv) begin
        if (emit) begin
          flag_r  <= '0;
          width_r <= '0;
          prec_r  <= '0;
          base_r  <= pfsp_pkg::BASE_DEC;
          mod_r   <= '0;
          acc_r   <= '0;
          phase_r <= pfsp_pkg::PH_IDLE;
          pend_r  <= pfsp_pkg::PM_NONE;
          len_r   <= '0;
        end else begin
          flag_r  <= flag_nxt;
          width_r <= width_nxt;
          prec_r  <= prec_nxt;
          base_r  <= base_nxt;
          mod_r   <= mod_nxt;
          acc_r   <= acc_nxt;
          phase_r <= phase_nxt;
          pend_r  <= pend_nxt;
          len_r   <= len_nxt;
        end
      end
      if (adv && emit) begin
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (adv && emit) begin
      conv_r   <= is_err ? 8'h00 : q_word.ch;
      oflag_r  <= flag_nxt;
      owidth_r <= width_nxt;
      oprec_r  <= prec_nxt;
      obase_r  <= base_nxt;
      omod_r   <= mod_nxt;
      oerr_r   <= is_err ? q_word.ch : 8'h00;
      oiserr_r <= is_err;
      olen_r   <= len_nxt;
    end
  end

  assign out_valid           = valid_r;
  assign out_conversion_char = conv_r;
  assign out_flag_bits       = oflag_r;
  assign out_field_width     = signed'(owidth_r);
  assign out_precision       = signed'(oprec_r);
  assign out_number_base     = obase_r;
  assign out_modifier_bits   = omod_r;
  assign out_error_char      = oerr_r;
  assign out_is_error        = oiserr_r;
  assign out_spec_length     = olen_r;

endmodule

`default_nettype wire
